// ----- hw/rtl/smf_pkg.sv -----
// Shared types, command codes and the file header table of the MIDI track encoder.
`timescale 1ns / 1ps

package smf_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_NOTE_ON = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_CTRL    = 3'd3,
    OP_PROGRAM = 3'd4,
    OP_CLOSE   = 3'd5
  } op_t;

  localparam logic [27:0] DELTA_MAX   = 28'hFFFFFFF;
  localparam logic [7:0]  ST_NOTE_OFF = 8'h80;
  localparam logic [7:0]  ST_NOTE_ON  = 8'h90;
  localparam logic [7:0]  ST_CTRL     = 8'hB0;
  localparam logic [7:0]  ST_PROGRAM  = 8'hC0;
  localparam logic [7:0]  META_BYTE   = 8'hFF;
  localparam logic [7:0]  META_EOT    = 8'h2F;
  localparam logic [7:0]  OFF_VEL     = 8'd64;
  localparam logic [4:0]  HDR_LEN     = 5'd29;
  localparam logic [31:0] HDR_TRACK_BYTES = 32'd7;

  // Fields of one input word.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] event_time;
    logic [7:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
  } smf_in_t;

  // One encoded command, ready to be sent byte by byte.
  typedef struct packed {
    logic            hdr;       // send the file header table
    logic            err;       // one error result
    logic [4:0]      nbytes;    // zero means one empty result
    logic [6:0][7:0] evb;       // delta bytes then message bytes, first at index 0
    logic [31:0]     len_rpt;   // track length shown on the last result
  } smf_item_t;

  // Standard MIDI file header, MThd, MTrk with zero length and tempo event.
  function automatic logic [7:0] header_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:  b = 8'h4D;
      5'd1:  b = 8'h54;
      5'd2:  b = 8'h68;
      5'd3:  b = 8'h64;
      5'd7:  b = 8'h06;
      5'd11: b = 8'h01;
      5'd12: b = 8'h01;
      5'd13: b = 8'hF4;
      5'd14: b = 8'h4D;
      5'd15: b = 8'h54;
      5'd16: b = 8'h72;
      5'd17: b = 8'h6B;
      5'd23: b = 8'hFF;
      5'd24: b = 8'h51;
      5'd25: b = 8'h03;
      5'd26: b = 8'h07;
      5'd27: b = 8'hA1;
      5'd28: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/smf_event_enc.sv -----
// Command checker and encoder: session state, delta time and message bytes.
`timescale 1ns / 1ps

module smf_event_enc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               output_mode,
  input  smf_pkg::smf_in_t   cmd,
  input  logic               take,
  output smf_pkg::smf_item_t item
);

  logic        open_r, open_nxt;
  logic        smode_r, smode_nxt;
  logic [63:0] last_time_r, last_time_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;

  logic        time_gt;
  logic [63:0] diff;
  logic [27:0] delta;
  logic [2:0]  grp;
  logic [3:0][7:0] vlq;
  logic [2:0][7:0] msg;
  logic [1:0]  mlen;
  logic        arg_err;
  logic        err;
  logic        emit;
  logic [55:0] evw;
  logic [31:0] count_sum;

  // Delta time since the last event, floored at zero and clamped.
  always_comb begin
    time_gt = cmd.event_time > last_time_r;
    diff    = cmd.event_time - last_time_r;
    if (!time_gt) begin
      delta = 28'd0;
    end else if (diff[63:28] != 36'd0) begin
      delta = smf_pkg::DELTA_MAX;
    end else begin
      delta = diff[27:0];
    end
  end

  // Variable-length quantity, most significant group first.
  always_comb begin
    vlq = '0;
    if (delta[27:21] != 7'd0) begin
      grp    = 3'd4;
      vlq[0] = {1'b1, delta[27:21]};
      vlq[1] = {1'b1, delta[20:14]};
      vlq[2] = {1'b1, delta[13:7]};
      vlq[3] = {1'b0, delta[6:0]};
    end else if (delta[20:14] != 7'd0) begin
      grp    = 3'd3;
      vlq[0] = {1'b1, delta[20:14]};
      vlq[1] = {1'b1, delta[13:7]};
      vlq[2] = {1'b0, delta[6:0]};
    end else if (delta[13:7] != 7'd0) begin
      grp    = 3'd2;
      vlq[0] = {1'b1, delta[13:7]};
      vlq[1] = {1'b0, delta[6:0]};
    end else begin
      grp    = 3'd1;
      vlq[0] = {1'b0, delta[6:0]};
    end
    if (!smode_r) begin
      grp = 3'd0;
      vlq = '0;
    end
  end

  // Message bytes and argument checks for each command.
  always_comb begin
    msg     = '0;
    mlen    = 2'd3;
    arg_err = (cmd.channel > 8'd15) || (cmd.data_first > 8'h7F);
    emit    = 1'b1;
    err     = 1'b0;
    case (cmd.opcode)
      smf_pkg::OP_OPEN: begin
        emit = 1'b0;
      end
      smf_pkg::OP_NOTE_ON: begin
        msg = {cmd.data_second, cmd.data_first, smf_pkg::ST_NOTE_ON | cmd.channel};
        arg_err = arg_err || (cmd.data_second > 8'h7F);
      end
      smf_pkg::OP_NOTE_OFF: begin
        msg = {smf_pkg::OFF_VEL, cmd.data_first, smf_pkg::ST_NOTE_OFF | cmd.channel};
      end
      smf_pkg::OP_CTRL: begin
        msg = {cmd.data_second, cmd.data_first, smf_pkg::ST_CTRL | cmd.channel};
        arg_err = arg_err || (cmd.data_second > 8'h7F);
      end
      smf_pkg::OP_PROGRAM: begin
        msg  = {8'h00, cmd.data_first, smf_pkg::ST_PROGRAM | cmd.channel};
        mlen = 2'd2;
      end
      smf_pkg::OP_CLOSE: begin
        msg     = {8'h00, smf_pkg::META_EOT, smf_pkg::META_BYTE};
        arg_err = 1'b0;
        emit    = smode_r;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (cmd.opcode != smf_pkg::OP_OPEN) begin
      err = err || !open_r || arg_err;
    end
  end

  // Pack the delta and message bytes of one event into one row.
  always_comb begin
    evw       = {24'd0, vlq} | ({32'd0, msg} << {grp, 3'b000});
    count_sum = byte_count_r + 32'(grp) + 32'(mlen);
  end

  // Item handed to the serializer.
  always_comb begin
    item         = '0;
    item.err     = err;
    item.evb     = evw;
    if (err) begin
      item.evb = '0;
    end else if (cmd.opcode == smf_pkg::OP_OPEN) begin
      item.hdr    = output_mode;
      item.nbytes = output_mode ? smf_pkg::HDR_LEN : 5'd0;
    end else if (emit) begin
      item.nbytes = 5'(grp) + 5'(mlen);
      if (cmd.opcode == smf_pkg::OP_CLOSE) begin
        item.len_rpt = count_sum;
      end
    end
  end

  // Session state advances when the serializer takes the item.
  always_comb begin
    open_nxt       = open_r;
    smode_nxt      = smode_r;
    last_time_nxt  = last_time_r;
    byte_count_nxt = byte_count_r;
    if (take && !err) begin
      if (cmd.opcode == smf_pkg::OP_OPEN) begin
        open_nxt       = 1'b1;
        smode_nxt      = output_mode;
        last_time_nxt  = 64'd0;
        byte_count_nxt = output_mode ? smf_pkg::HDR_TRACK_BYTES : 32'd0;
      end else begin
        if (cmd.opcode == smf_pkg::OP_CLOSE) begin
          open_nxt = 1'b0;
        end
        if (smode_r) begin
          byte_count_nxt = count_sum;
          if (time_gt) begin
            last_time_nxt = cmd.event_time;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      smode_r      <= 1'b0;
      last_time_r  <= 64'd0;
      byte_count_r <= 32'd0;
    end else begin
      open_r       <= open_nxt;
      smode_r      <= smode_nxt;
      last_time_r  <= last_time_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

`ifndef SYNTH
  // Stream mode never adds to the track count.
  a_stream_count: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r && !smode_r) |-> (byte_count_r == 32'd0))
    else $error("track count moved in stream mode");

  // An open always leaves the session open.
  a_open_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.opcode == smf_pkg::OP_OPEN) |=> open_r)
    else $error("open did not start a session");

  // An error leaves the session flag alone.
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (take && err) |=> (open_r == $past(open_r)))
    else $error("error changed the session");
`endif

endmodule

// ----- hw/rtl/smf_byte_ser.sv -----
// Item buffer and byte serializer feeding the registered output word.
`timescale 1ns / 1ps

module smf_byte_ser (
  input  logic               clk,
  input  logic               rst_n,
  input  smf_pkg::smf_item_t item,
  input  logic               item_valid,
  output logic               item_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  smf_pkg::smf_item_t buf_r;
  logic        buf_v_r, buf_v_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        ov_r;
  logic [7:0]  byte_r;
  logic        bval_r;
  logic        stat_r;
  logic        last_r;
  logic [31:0] len_r;

  logic        load;
  logic        fin;
  logic [7:0]  cur_byte;

  // Current byte and whether it closes the item.
  always_comb begin
    load     = !ov_r || out_tready;
    fin      = (buf_r.nbytes == 5'd0) || (idx_r == buf_r.nbytes - 5'd1);
    cur_byte = buf_r.hdr ? smf_pkg::header_byte(idx_r) : buf_r.evb[idx_r[2:0]];
    item_ready = !buf_v_r || (load && fin);
  end

  // Byte index and buffer occupancy.
  always_comb begin
    buf_v_nxt = buf_v_r;
    idx_nxt   = idx_r;
    if (buf_v_r && load) begin
      idx_nxt = idx_r + 5'd1;
      if (fin) begin
        buf_v_nxt = 1'b0;
      end
    end
    if (item_valid && item_ready) begin
      buf_v_nxt = 1'b1;
      idx_nxt   = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      idx_r   <= 5'd0;
      ov_r    <= 1'b0;
    end else begin
      buf_v_r <= buf_v_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        ov_r <= buf_v_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      buf_r <= item;
    end
    if (load && buf_v_r) begin
      byte_r <= (buf_r.nbytes == 5'd0) ? 8'h00 : cur_byte;
      bval_r <= buf_r.nbytes != 5'd0;
      stat_r <= buf_r.err;
      last_r <= fin;
      len_r  <= fin ? buf_r.len_rpt : 32'd0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {len_r, byte_r};
  assign out_tuser  = {stat_r, bval_r};
  assign out_tlast  = last_r;

`ifndef SYNTH
  // An empty result is always the only result of its item.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !bval_r) |-> out_tlast)
    else $error("empty result not marked last");

  // Error results carry no byte.
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && stat_r) |-> !bval_r)
    else $error("error result carries a byte");

  // A length is shown only on the last result.
  a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && len_r != 32'd0) |-> out_tlast)
    else $error("length on a result that is not last");

  // The index never runs past the header.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r |-> (idx_r < smf_pkg::HDR_LEN))
    else $error("byte index out of range");
`endif

endmodule

// ----- hw/rtl/smf_track_event_encoder.sv -----
// Top level of the MIDI track event encoder: input register, encoder and serializer.
//
//   Port group | Direction | Content
//   in_*       | slave     | one MIDI command word
//   out_*      | master    | one output byte word per result
//   cfg_*      | write     | output mode register
//
// Each command word is registered, encoded combinationally and sent one byte per
// cycle unless out_tready stalls; a command yields one word per byte, or one empty
// word if it has none. The byte serializer sets the rate; the next command is taken
// on the cycle its predecessor's last byte moves to the output register.
// Reset (rst_n, synchronous, active low) closes the session and clears all counts.
// A stall on out_tready holds the output word and backs up into in_tready.
`timescale 1ns / 1ps

module smf_track_event_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // output_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,      // event_time, channel, data_first, data_second
  input  logic [2:0]  in_tuser,      // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // out_byte, length_report
  output logic [1:0]  out_tuser,     // byte_valid, status
  output logic        out_tlast      // last
);

  logic               mode_r;
  logic               in_v_r;
  smf_pkg::smf_in_t   in_r;
  smf_pkg::smf_item_t item;
  logic               item_ready;

  // Output mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign in_tready = !in_v_r || item_ready;

  // Input word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.opcode      <= in_tuser;
      in_r.event_time  <= in_tdata[63:0];
      in_r.channel     <= in_tdata[71:64];
      in_r.data_first  <= in_tdata[79:72];
      in_r.data_second <= in_tdata[87:80];
    end
  end

  smf_event_enc u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .output_mode (mode_r),
    .cmd         (in_r),
    .take        (in_v_r && item_ready),
    .item        (item)
  );

  smf_byte_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (in_v_r),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the MIDI track event encoder, with its own byte-level predictor.
`timescale 1ns / 1ps

module testbench;

  // Opcodes outside the command set, used to provoke error results.
  localparam logic [2:0]   OP_BAD_LO = 3'd6;
  localparam logic [2:0]   OP_BAD_HI = 3'd7;

  // MIDI status and meta bytes.
  localparam logic [7:0]   MSG_NOTE_OFF = 8'h80;
  localparam logic [7:0]   MSG_NOTE_ON  = 8'h90;
  localparam logic [7:0]   MSG_CTRL     = 8'hB0;
  localparam logic [7:0]   MSG_PROGRAM  = 8'hC0;
  localparam logic [7:0]   MSG_META     = 8'hFF;
  localparam logic [7:0]   MSG_EOT      = 8'h2F;
  localparam logic [7:0]   RELEASE_VEL  = 8'd64;
  localparam logic [7:0]   CHAN_TOP     = 8'd15;
  localparam logic [7:0]   DATA_TOP     = 8'h7F;
  localparam logic [31:0]  VLQ_CLAMP    = 32'h0FFF_FFFF;
  localparam logic [31:0]  HEADER_TRACK = 32'd7;
  localparam int unsigned  HEADER_BYTES = 29;

  // File header, first byte in the top bits.
  localparam logic [231:0] SMF_HEADER = {
    8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hF4,
    8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20
  };

  localparam int unsigned  CYCLE_LIMIT  = 500000;
  localparam int unsigned  SETTLE       = 8;
  localparam int unsigned  HALF_ITEMS   = 57;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] event_time;
    logic [7:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        status;
    logic [31:0] length;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;     // event_time, channel, data_first, data_second
  logic [2:0]  in_tuser = '0;     // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // out_byte, length_report
  logic [1:0]  out_tuser;         // byte_valid, status
  logic        out_tlast;

  smf_track_event_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Pending commands, the command on the bus and the bytes still owed by the encoder.
  cmd_t        cmd_q[$];
  cmd_t        cur_cmd;
  result_t     byte_q[$];

  // Predictor state: mode register copy and the open session.
  logic        mode_reg = 1'b0;
  logic        sess_open = 1'b0;
  logic        sess_file = 1'b0;
  logic [63:0] last_ms = '0;
  logic [31:0] track_bytes = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_cmds = 0;
  int unsigned n_results = 0;
  int unsigned n_err_results = 0;
  int unsigned n_file_opens = 0;
  int unsigned n_reports = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the bytes that one accepted command produces and updates the session.
  task automatic predict_command(input cmd_t c);
    logic [7:0]  seq_q[$];
    logic [7:0]  msg[3];
    logic [7:0]  second;
    logic [7:0]  hi;
    logic [63:0] gap;
    logic [31:0] dlt;
    logic [31:0] chunk;
    logic        bad;
    logic        closing;
    int unsigned msg_len;
    int unsigned groups;
    int unsigned g;
    int unsigned i;
    result_t     r;
    bad = 1'b0;
    closing = 1'b0;
    msg_len = 0;
    second = c.data_second;
    if (c.opcode == smf_pkg::OP_OPEN) begin
      sess_open = 1'b1;
      sess_file = mode_reg;
      last_ms = '0;
      track_bytes = '0;
      if (sess_file) begin
        for (i = 0; i < HEADER_BYTES; i++) seq_q.push_back(SMF_HEADER[(28 - i) * 8 +: 8]);
        track_bytes = HEADER_TRACK;
        n_file_opens++;
      end
    end else if (c.opcode > smf_pkg::OP_CLOSE || !sess_open) begin
      bad = 1'b1;
    end else if (c.opcode == smf_pkg::OP_CLOSE) begin
      closing = 1'b1;
      if (sess_file) begin
        msg[0] = MSG_META;
        msg[1] = MSG_EOT;
        msg[2] = 8'h00;
        msg_len = 3;
      end
      sess_open = 1'b0;
    end else if (c.opcode == smf_pkg::OP_PROGRAM) begin
      if (c.channel > CHAN_TOP || c.data_first > DATA_TOP) begin
        bad = 1'b1;
      end else begin
        msg[0] = MSG_PROGRAM | c.channel;
        msg[1] = c.data_first;
        msg_len = 2;
      end
    end else begin
      case (c.opcode)
        smf_pkg::OP_NOTE_ON: hi = MSG_NOTE_ON;
        smf_pkg::OP_NOTE_OFF: begin
          hi = MSG_NOTE_OFF;
          second = RELEASE_VEL;
        end
        default: hi = MSG_CTRL;
      endcase
      if (c.channel > CHAN_TOP || c.data_first > DATA_TOP || second > DATA_TOP) begin
        bad = 1'b1;
      end else begin
        msg[0] = hi | c.channel;
        msg[1] = c.data_first;
        msg[2] = second;
        msg_len = 3;
      end
    end

    // Events carry a variable-length delta in file mode, most significant group first.
    if (!bad && msg_len > 0) begin
      if (sess_file) begin
        gap = (c.event_time > last_ms) ? c.event_time - last_ms : 64'd0;
        dlt = (gap > {32'd0, VLQ_CLAMP}) ? VLQ_CLAMP : gap[31:0];
        groups = 1;
        while (groups < 4 && (dlt >> (7 * groups)) != 0) groups++;
        for (g = groups; g > 0; g--) begin
          chunk = dlt >> (7 * (g - 1));
          seq_q.push_back({g > 1, chunk[6:0]});
        end
        track_bytes = track_bytes + groups + msg_len;
        if (c.event_time > last_ms) last_ms = c.event_time;
      end
      for (i = 0; i < msg_len; i++) seq_q.push_back(msg[i]);
    end

    if (bad) begin
      r = '{data_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, status: 1'b1, length: '0};
      byte_q.push_back(r);
      n_err_results++;
    end else if (seq_q.size() == 0) begin
      r = '{data_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, status: 1'b0, length: '0};
      byte_q.push_back(r);
    end else begin
      for (i = 0; i < seq_q.size(); i++) begin
        r = '{data_byte: seq_q[i], byte_valid: 1'b1, last: 1'b0, status: 1'b0, length: '0};
        if (i == seq_q.size() - 1) begin
          r.last = 1'b1;
          if (closing && sess_file) begin
            r.length = track_bytes;
            n_reports++;
          end
        end
        byte_q.push_back(r);
      end
    end
  endtask

  // Drives the command words and predicts each one as it is taken.
  always @(posedge clk) begin : cmd_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_command(cur_cmd);
        n_cmds++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_cmd.opcode;
          in_tdata <= {cur_cmd.data_second, cur_cmd.data_first, cur_cmd.channel,
                       cur_cmd.event_time};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Checks every output word against the oldest expected byte.
  always @(posedge clk) begin : byte_checker
    result_t want;
    result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        got = '{data_byte: out_tdata[7:0], byte_valid: out_tuser[0], last: out_tlast,
                status: out_tuser[1], length: out_tdata[39:8]};
        if (byte_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("ERROR: unexpected word byte=%h valid=%b last=%b status=%b len=%h",
                     got.data_byte, got.byte_valid, got.last, got.status, got.length);
        end else begin
          want = byte_q.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("ERROR: word %0d exp byte=%h valid=%b last=%b status=%b len=%h",
                       n_results, want.data_byte, want.byte_valid, want.last, want.status,
                       want.length);
              $display("       got byte=%h valid=%b last=%b status=%b len=%h",
                       got.data_byte, got.byte_valid, got.last, got.status, got.length);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(input logic [2:0] op, input logic [63:0] t, input logic [7:0] ch,
                          input logic [7:0] d1, input logic [7:0] d2);
    cmd_t c;
    c = '{opcode: op, event_time: t, channel: ch, data_first: d1, data_second: d2};
    cmd_q.push_back(c);
    n_queued++;
  endtask

  function automatic logic [7:0] rand_chan();
    return ($urandom_range(99) < 90) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_data();
    return ($urandom_range(99) < 92) ? 8'($urandom_range(127)) : 8'($urandom_range(255));
  endfunction

  // Next event time: mostly short steps, some long ones, some jumps back or far out.
  function automatic logic [63:0] next_time(input logic [63:0] t);
    int unsigned pick;
    logic [63:0] nt;
    pick = $urandom_range(99);
    if (pick < 45)      nt = t + $urandom_range(127);
    else if (pick < 62) nt = t + $urandom_range(32'h3FFF, 32'h80);
    else if (pick < 74) nt = t + $urandom_range(32'h1F_FFFF, 32'h4000);
    else if (pick < 84) nt = t + $urandom_range(32'h0FFF_FFFF, 32'h20_0000);
    else if (pick < 88) nt = {$urandom, $urandom};
    else if (pick < 96) nt = t - $urandom_range(300);
    else                nt = t + {32'd0, VLQ_CLAMP} + $urandom;
    return nt;
  endfunction

  // One session: at times a bad command, open, events of random content, usually a close.
  task automatic queue_session(input int unsigned n_ev);
    logic [63:0] t;
    logic [2:0]  op;
    int unsigned k;
    int unsigned pick;
    if ($urandom_range(9) == 0)
      push_cmd(3'($urandom_range(OP_BAD_HI, smf_pkg::OP_NOTE_ON)), {$urandom, $urandom},
               8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    t = $urandom_range(1000);
    push_cmd(smf_pkg::OP_OPEN, t, rand_chan(), rand_data(), rand_data());
    for (k = 0; k < n_ev; k++) begin
      pick = $urandom_range(99);
      t = next_time(t);
      if (pick < 3)      op = ($urandom_range(1) != 0) ? OP_BAD_HI : OP_BAD_LO;
      else if (pick < 5) op = smf_pkg::OP_OPEN;
      else               op = 3'($urandom_range(smf_pkg::OP_PROGRAM, smf_pkg::OP_NOTE_ON));
      push_cmd(op, t, rand_chan(), rand_data(), rand_data());
    end
    if ($urandom_range(9) != 0)
      push_cmd(smf_pkg::OP_CLOSE, next_time(t), rand_chan(), rand_data(), rand_data());
  endtask

  // Waits until every command is taken and every expected byte has come out.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_tvalid || byte_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mode_reg = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic mode_a, input logic mode_b);
    int unsigned target;
    int unsigned half;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (half = 0; half < 2; half++) begin
      write_mode(half == 0 ? mode_a : mode_b);
      target = n_queued + HALF_ITEMS;
      while (n_queued < target) queue_session($urandom_range(20, 3));
    end
  endtask

  initial begin
    logic [63:0] t;
    rst_n = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 54;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stream mode: commands before open, every command opcode, range errors, a bad opcode, close.
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd10, 8'd0, 8'd60, 8'd100);
    push_cmd(smf_pkg::OP_CLOSE, 64'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd1, CHAN_TOP, DATA_TOP, DATA_TOP);
    push_cmd(smf_pkg::OP_NOTE_OFF, 64'd2, 8'd5, 8'd60, 8'hFF);
    push_cmd(smf_pkg::OP_CTRL, 64'd3, 8'd3, DATA_TOP, 8'd0);
    push_cmd(smf_pkg::OP_PROGRAM, 64'd4, CHAN_TOP, DATA_TOP, 8'hFF);
    push_cmd(smf_pkg::OP_CTRL, 64'd5, 8'hFF, 8'd1, 8'd1);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd6, 8'd1, 8'h80, 8'd1);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd7, 8'd1, 8'd1, 8'h80);
    push_cmd(smf_pkg::OP_PROGRAM, 64'd8, 8'd1, 8'hFF, 8'd0);
    push_cmd(OP_BAD_LO, 64'd9, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_CLOSE, 64'd10, 8'd0, 8'd0, 8'd0);

    // File mode: header, each delta length, clamping, time going back, reopen.
    write_mode(1'b1);
    push_cmd(smf_pkg::OP_OPEN, 64'd12345, 8'd0, 8'd0, 8'd0);
    t = 64'd0;
    push_cmd(smf_pkg::OP_NOTE_ON, t, 8'd0, 8'd64, 8'd90);
    t = t + 64'h7F;
    push_cmd(smf_pkg::OP_CTRL, t, 8'd9, 8'd7, 8'd100);
    t = t + 64'h80;
    push_cmd(smf_pkg::OP_NOTE_OFF, t, 8'd0, 8'd64, 8'd0);
    t = t + 64'h3FFF;
    push_cmd(smf_pkg::OP_PROGRAM, t, 8'd2, 8'd10, 8'd0);
    t = t + 64'h4000;
    push_cmd(smf_pkg::OP_NOTE_ON, t, 8'd2, 8'd70, 8'd1);
    t = t + 64'h20_0000;
    push_cmd(smf_pkg::OP_NOTE_ON, t, 8'd2, 8'd71, 8'd1);
    t = t + {32'd0, VLQ_CLAMP};
    push_cmd(smf_pkg::OP_CTRL, t, 8'd4, 8'd1, 8'd2);
    push_cmd(smf_pkg::OP_NOTE_OFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2, 8'd70, 8'd0);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd5, 8'd2, 8'd72, 8'd3);
    push_cmd(OP_BAD_HI, 64'd6, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_OPEN, 64'd0, 8'd0, 8'd0, 8'd0);
    push_cmd(smf_pkg::OP_NOTE_ON, 64'd300, 8'd0, 8'd1, 8'd1);
    push_cmd(smf_pkg::OP_CLOSE, 64'h8000_0000_0000_0000, 8'd0, 8'd0, 8'd0);

    // Random sessions under three idling patterns, both modes in the first two.
    run_phase(36, 54, 1'b1, 1'b0);
    run_phase(54, 36, 1'b0, 1'b1);
    run_phase(0, 0, 1'b1, 1'b1);

    wait_idle();
    repeat (SETTLE) @(negedge clk);
    failures += byte_q.size();
    $display("tb: %0d commands and %0d output words checked, %0d error results,",
             n_cmds, n_results, n_err_results);
    $display("tb: %0d file headers and %0d track length reports, %0d mismatches",
             n_file_opens, n_reports, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/smf_pkg.sv
hw/rtl/smf_event_enc.sv
hw/rtl/smf_byte_ser.sv
hw/rtl/smf_track_event_encoder.sv
tb/testbench.sv
